>>> rtl/ste_pkg.sv
// Shared types and constants for the symbol table engine.
package ste_pkg;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned TYPE_W = 64;
  localparam int unsigned ADDR_W = 32;

  // Operation codes carried on the command field.
  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_SEARCH  = 2'd1,
    CMD_DELETE  = 2'd2,
    CMD_DISPLAY = 2'd3
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_RESP  = 2'd1,
    S_SCAN  = 2'd2,
    S_SHIFT = 2'd3
  } state_t;

  // One table entry as held in the entry memory.
  typedef struct packed {
    logic [KEY_W-1:0]         key;
    logic [TYPE_W-1:0]        typ;
    logic signed [ADDR_W-1:0] addr;
  } entry_t;

endpackage

>>> rtl/symbol_table_engine.sv
// Symbol table engine: ordered symbol table with insert, search, delete and display.
//
// The table holds up to DEPTH entries in one synchronous memory with a single read
// and a single write port, and handles one request at a time. Insert, and display of
// an empty table, answer from the response state. Search and delete walk the table
// from the start, reading one entry per cycle through the memory read port while the
// output register can take a result; a miss gives a not-found result once every stored
// entry has been read. A delete hit then moves each later entry down by one place, again
// one entry per cycle through the same port. Display reads every stored entry in order,
// one result per cycle while out_ready is held high. New requests are taken once
// the previous request has produced its last result into the output register, and for
// a delete hit once the later entries have been moved, even if that result has not yet
// been taken downstream.
module symbol_table_engine #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Request channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_cmd,
  input  logic [ste_pkg::KEY_W-1:0]          in_sym_key,
  input  logic [ste_pkg::TYPE_W-1:0]         in_type_word,
  input  logic signed [ste_pkg::ADDR_W-1:0]  in_addr_value,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_status,
  output logic [ste_pkg::KEY_W-1:0]          out_key,
  output logic [ste_pkg::TYPE_W-1:0]         out_type,
  output logic signed [ste_pkg::ADDR_W-1:0]  out_addr,
  output logic                               out_last
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Entry memory.
  ste_pkg::entry_t mem [DEPTH];

  // Control and datapath registers.
  ste_pkg::state_t  state_r, state_nxt;
  ste_pkg::cmd_t    cmd_r, cmd_nxt;
  logic [ste_pkg::KEY_W-1:0] key_r, key_nxt;
  ste_pkg::status_t resp_r, resp_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    iss_r, iss_nxt;
  logic             dvld_r, dvld_nxt;
  logic [IW-1:0]    didx_r, didx_nxt;
  ste_pkg::entry_t  rdata_r;

  logic             out_valid_r;
  ste_pkg::status_t out_status_r, out_status_nxt;
  ste_pkg::entry_t  out_entry_r, out_entry_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_load;

  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  ste_pkg::entry_t  mem_wdata;

  logic accept, out_free, more, match, at_last, consume, issue;

  // Handshake and scan status.
  assign in_ready = (state_r == ste_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign more     = (iss_r < count_r);
  assign match    = dvld_r && (rdata_r.key == key_r);
  assign at_last  = ((CW'(didx_r) + CW'(1)) == count_r);

  // An entry read from memory is used up by the scan (when the output can take a
  // result) or by the shift (always).
  always_comb begin
    consume = 1'b0;
    if (state_r == ste_pkg::S_SCAN) begin
      consume = dvld_r && out_free;
    end else if (state_r == ste_pkg::S_SHIFT) begin
      consume = dvld_r;
    end
  end

  // A new read is issued while entries remain and the read register is free.
  assign issue = ((state_r == ste_pkg::S_SCAN) || (state_r == ste_pkg::S_SHIFT))
                 && more && (!dvld_r || consume);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ste_pkg::S_IDLE: begin
        if (accept) begin
          if (ste_pkg::cmd_t'(in_cmd) == ste_pkg::CMD_INSERT) begin
            state_nxt = ste_pkg::S_RESP;
          end else if (ste_pkg::cmd_t'(in_cmd) == ste_pkg::CMD_DISPLAY
                       && count_r == '0) begin
            state_nxt = ste_pkg::S_RESP;
          end else begin
            state_nxt = ste_pkg::S_SCAN;
          end
        end
      end
      ste_pkg::S_RESP: begin
        if (out_free) begin
          state_nxt = ste_pkg::S_IDLE;
        end
      end
      ste_pkg::S_SCAN: begin
        if (consume) begin
          if (cmd_r == ste_pkg::CMD_DISPLAY) begin
            if (at_last) begin
              state_nxt = ste_pkg::S_IDLE;
            end
          end else if (match) begin
            state_nxt = (cmd_r == ste_pkg::CMD_DELETE) ? ste_pkg::S_SHIFT
                                                       : ste_pkg::S_IDLE;
          end
        end else if (!dvld_r && !more && out_free
                     && cmd_r != ste_pkg::CMD_DISPLAY) begin
          state_nxt = ste_pkg::S_IDLE;
        end
      end
      ste_pkg::S_SHIFT: begin
        if (!dvld_r && !more) begin
          state_nxt = ste_pkg::S_IDLE;
        end
      end
      default: state_nxt = ste_pkg::S_IDLE;
    endcase
  end

  // Datapath control: memory writes, counters and result loading.
  always_comb begin
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    resp_nxt       = resp_r;
    count_nxt      = count_r;
    iss_nxt        = issue ? (iss_r + CW'(1)) : iss_r;
    dvld_nxt       = issue ? 1'b1 : (consume ? 1'b0 : dvld_r);
    didx_nxt       = issue ? iss_r[IW-1:0] : didx_r;
    mem_we         = 1'b0;
    mem_waddr      = count_r[IW-1:0];
    mem_wdata      = '{key: in_sym_key, typ: in_type_word, addr: in_addr_value};
    out_load       = 1'b0;
    out_status_nxt = ste_pkg::ST_OK;
    out_entry_nxt  = '0;
    out_last_nxt   = 1'b1;
    case (state_r)
      ste_pkg::S_IDLE: begin
        if (accept) begin
          cmd_nxt  = ste_pkg::cmd_t'(in_cmd);
          key_nxt  = in_sym_key;
          iss_nxt  = '0;
          dvld_nxt = 1'b0;
          resp_nxt = ste_pkg::ST_OK;
          if (ste_pkg::cmd_t'(in_cmd) == ste_pkg::CMD_INSERT) begin
            if (count_r == CW'(DEPTH)) begin
              resp_nxt = ste_pkg::ST_FULL;
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end else if (ste_pkg::cmd_t'(in_cmd) == ste_pkg::CMD_DISPLAY) begin
            resp_nxt = ste_pkg::ST_EMPTY;
          end
        end
      end
      ste_pkg::S_RESP: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = resp_r;
        end
      end
      ste_pkg::S_SCAN: begin
        if (consume) begin
          if (cmd_r == ste_pkg::CMD_DISPLAY) begin
            out_load      = 1'b1;
            out_entry_nxt = rdata_r;
            out_last_nxt  = at_last;
          end else if (match) begin
            out_load      = 1'b1;
            out_entry_nxt = rdata_r;
            // Start moving the entries after the removed one down by one place.
            iss_nxt       = CW'(didx_r) + CW'(1);
            dvld_nxt      = 1'b0;
          end
        end else if (!dvld_r && !more && out_free
                     && cmd_r != ste_pkg::CMD_DISPLAY) begin
          out_load       = 1'b1;
          out_status_nxt = ste_pkg::ST_NOT_FOUND;
        end
      end
      ste_pkg::S_SHIFT: begin
        if (consume) begin
          mem_we    = 1'b1;
          mem_waddr = didx_r - IW'(1);
          mem_wdata = rdata_r;
        end
        if (!dvld_r && !more) begin
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rdata_r <= mem[iss_r[IW-1:0]];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ste_pkg::S_IDLE;
      count_r     <= '0;
      dvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      dvld_r  <= dvld_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    key_r  <= key_nxt;
    resp_r <= resp_nxt;
    iss_r  <= iss_nxt;
    didx_r <= didx_nxt;
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_entry_r  <= out_entry_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  // Result outputs.
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_key    = out_entry_r.key;
  assign out_type   = out_entry_r.typ;
  assign out_addr   = out_entry_r.addr;
  assign out_last   = out_last_r;

endmodule

>>> test/tb_symbol_table_engine.sv
// Self-checking testbench for the symbol table engine: directed requests, then random traffic.
module tb_symbol_table_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH         = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 3 * DEPTH + 40;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int MAX_REPORTS   = 10;

  localparam logic [ste_pkg::KEY_W-1:0]  KEY_ONES  = '1;
  localparam logic [ste_pkg::KEY_W-1:0]  KEY_ZERO  = '0;
  localparam logic [ste_pkg::KEY_W-1:0]  KEY_MAIN  = "main";
  localparam logic [ste_pkg::KEY_W-1:0]  KEY_COUNT = "count";
  localparam logic [ste_pkg::KEY_W-1:0]  KEY_X     = "x";
  localparam logic [ste_pkg::TYPE_W-1:0] TYPE_INT  = "int";
  localparam logic [ste_pkg::TYPE_W-1:0] TYPE_FLT  = "float";
  localparam logic [ste_pkg::TYPE_W-1:0] TYPE_CHR  = "char";
  localparam logic signed [ste_pkg::ADDR_W-1:0] ADDR_MIN = 32'sh8000_0000;
  localparam logic signed [ste_pkg::ADDR_W-1:0] ADDR_MAX = 32'sh7FFF_FFFF;

  // One result as it should appear on the output channel.
  typedef struct packed {
    ste_pkg::status_t                  status;
    logic [ste_pkg::KEY_W-1:0]         key;
    logic [ste_pkg::TYPE_W-1:0]        typ;
    logic signed [ste_pkg::ADDR_W-1:0] addr;
    logic                              last;
  } reply_t;

  // One directed request, with an optional hand-typed single result.
  typedef struct packed {
    ste_pkg::cmd_t                     cmd;
    logic [ste_pkg::KEY_W-1:0]         key;
    logic [ste_pkg::TYPE_W-1:0]        typ;
    logic signed [ste_pkg::ADDR_W-1:0] addr;
    logic                              fixed;
    ste_pkg::status_t                  fixed_status;
  } stim_row_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [1:0]                         in_cmd = '0;
  logic [ste_pkg::KEY_W-1:0]          in_sym_key = '0;
  logic [ste_pkg::TYPE_W-1:0]         in_type_word = '0;
  logic signed [ste_pkg::ADDR_W-1:0]  in_addr_value = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [1:0]                         out_status;
  logic [ste_pkg::KEY_W-1:0]          out_key;
  logic [ste_pkg::TYPE_W-1:0]         out_type;
  logic signed [ste_pkg::ADDR_W-1:0]  out_addr;
  logic                               out_last;

  // Shadow copy of the table contents.
  logic [ste_pkg::KEY_W-1:0]          tbl_key  [DEPTH];
  logic [ste_pkg::TYPE_W-1:0]         tbl_type [DEPTH];
  logic signed [ste_pkg::ADDR_W-1:0]  tbl_addr [DEPTH];
  int                                 tbl_count = 0;

  reply_t awaited[$];

  int  error_count = 0;
  int  results_seen = 0;
  int  requests_sent = 0;
  int  op_count [4] = '{0, 0, 0, 0};
  int  full_inserts = 0;
  int  longest_listing = 0;
  int  holds_done = 0;
  int  cycle_count = 0;
  int  send_run = 0;
  int  recv_run = 0;
  bit  hold_outputs = 1'b0;

  symbol_table_engine #(.DEPTH(DEPTH)) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_sym_key    (in_sym_key),
    .in_type_word  (in_type_word),
    .in_addr_value (in_addr_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_key       (out_key),
    .out_type      (out_type),
    .out_addr      (out_addr),
    .out_last      (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Wait before the next request or result: mostly random, with bursts of back-to-back traffic.
  function automatic int draw_wait(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) begin
      run = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic void queue_reply(ste_pkg::status_t st,
                                      logic [ste_pkg::KEY_W-1:0] key,
                                      logic [ste_pkg::TYPE_W-1:0] typ,
                                      logic signed [ste_pkg::ADDR_W-1:0] addr,
                                      logic last);
    awaited.push_back('{st, key, typ, addr, last});
  endfunction

  // Apply one request to the shadow table and queue the results it should produce.
  function automatic void apply_table_op(ste_pkg::cmd_t cmd,
                                         logic [ste_pkg::KEY_W-1:0] key,
                                         logic [ste_pkg::TYPE_W-1:0] typ,
                                         logic signed [ste_pkg::ADDR_W-1:0] addr);
    int hit;
    int i;
    hit = -1;
    for (i = tbl_count - 1; i >= 0; i--) begin
      if (tbl_key[i] == key) hit = i;
    end
    case (cmd)
      ste_pkg::CMD_INSERT: begin
        if (tbl_count >= DEPTH) begin
          full_inserts++;
          queue_reply(ste_pkg::ST_FULL, '0, '0, '0, 1'b1);
        end else begin
          tbl_key[tbl_count]  = key;
          tbl_type[tbl_count] = typ;
          tbl_addr[tbl_count] = addr;
          tbl_count++;
          queue_reply(ste_pkg::ST_OK, '0, '0, '0, 1'b1);
        end
      end
      ste_pkg::CMD_SEARCH: begin
        if (hit < 0) queue_reply(ste_pkg::ST_NOT_FOUND, '0, '0, '0, 1'b1);
        else queue_reply(ste_pkg::ST_OK, tbl_key[hit], tbl_type[hit], tbl_addr[hit], 1'b1);
      end
      ste_pkg::CMD_DELETE: begin
        if (hit < 0) begin
          queue_reply(ste_pkg::ST_NOT_FOUND, '0, '0, '0, 1'b1);
        end else begin
          queue_reply(ste_pkg::ST_OK, tbl_key[hit], tbl_type[hit], tbl_addr[hit], 1'b1);
          // Later entries close the gap, keeping table order.
          for (i = hit; i < tbl_count - 1; i++) begin
            tbl_key[i]  = tbl_key[i + 1];
            tbl_type[i] = tbl_type[i + 1];
            tbl_addr[i] = tbl_addr[i + 1];
          end
          tbl_count--;
        end
      end
      default: begin
        if (tbl_count == 0) begin
          queue_reply(ste_pkg::ST_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          for (i = 0; i < tbl_count; i++) begin
            queue_reply(ste_pkg::ST_OK, tbl_key[i], tbl_type[i], tbl_addr[i],
                        i == tbl_count - 1);
          end
          if (tbl_count > longest_listing) longest_listing = tbl_count;
        end
      end
    endcase
  endfunction

  // Keys: often one already stored, often a common name, now and then anything at all.
  function automatic logic [ste_pkg::KEY_W-1:0] pick_key();
    logic [ste_pkg::KEY_W-1:0] key;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4 && tbl_count > 0) begin
      key = tbl_key[$urandom_range(0, tbl_count - 1)];
    end else if (sel < 8) begin
      case ($urandom_range(0, 7))
        0: key = "main";
        1: key = "count";
        2: key = "buf";
        3: key = "idx";
        4: key = "tmp";
        5: key = "ptr";
        6: key = "x";
        default: key = "result_v";
      endcase
    end else if (sel == 8) begin
      key = {$urandom, $urandom};
    end else begin
      key = $urandom_range(0, 1) ? KEY_ONES : KEY_ZERO;
    end
    return key;
  endfunction

  // Offer one request and hold it until the block takes it, then predict its results.
  task automatic send_request(ste_pkg::cmd_t cmd, logic [ste_pkg::KEY_W-1:0] key,
                              logic [ste_pkg::TYPE_W-1:0] typ,
                              logic signed [ste_pkg::ADDR_W-1:0] addr);
    int gap;
    gap = draw_wait(send_run);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_sym_key    <= key;
    in_type_word  <= typ;
    in_addr_value <= addr;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    op_count[cmd]++;
    apply_table_op(cmd, key, typ, addr);
  endtask

  task automatic send_random(int w_ins, int w_srch, int w_del, int w_disp);
    int roll;
    ste_pkg::cmd_t cmd;
    roll = $urandom_range(0, w_ins + w_srch + w_del + w_disp - 1);
    if (roll < w_ins) cmd = ste_pkg::CMD_INSERT;
    else if (roll < w_ins + w_srch) cmd = ste_pkg::CMD_SEARCH;
    else if (roll < w_ins + w_srch + w_del) cmd = ste_pkg::CMD_DELETE;
    else cmd = ste_pkg::CMD_DISPLAY;
    send_request(cmd, pick_key(), {$urandom, $urandom}, $urandom);
  endtask

  // Stop offering requests until every outstanding result has arrived.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, one long hold-off on request, and the field checks.
  initial begin
    int stall;
    reply_t want;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_outputs) begin
        hold_outputs = 1'b0;
        holds_done++;
        stall = HOLD_CYCLES;
      end else begin
        stall = draw_wait(recv_run);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
      if (awaited.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("Unexpected result: status %0d key %h type %h addr %0d last %0b",
                   out_status, out_key, out_type, out_addr, out_last);
      end else begin
        want = awaited.pop_front();
        if (out_status !== want.status || out_key !== want.key || out_type !== want.typ ||
            out_addr !== want.addr || out_last !== want.last) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("Result %0d mismatch: expected status %0d key %h type %h addr %0d last %0b",
                     results_seen, want.status, want.key, want.typ, want.addr, want.last);
            $display("  got status %0d key %h type %h addr %0d last %0b",
                     out_status, out_key, out_type, out_addr, out_last);
          end
        end
      end
    end
  end

  // Guard against a hung block.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding",
             cycle_count, awaited.size());
    $display("symbol_table_engine test failed");
    $finish;
  end

  // Stimulus.
  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    int n;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests: empty table, field extremes, duplicates, shifts on delete.
    rows.push_back('{ste_pkg::CMD_DISPLAY, KEY_ZERO, '0, '0, 1'b1, ste_pkg::ST_EMPTY});
    rows.push_back('{ste_pkg::CMD_SEARCH, KEY_ZERO, '1, ADDR_MIN, 1'b1, ste_pkg::ST_NOT_FOUND});
    rows.push_back('{ste_pkg::CMD_DELETE, KEY_ONES, '0, ADDR_MAX, 1'b1, ste_pkg::ST_NOT_FOUND});
    rows.push_back('{ste_pkg::CMD_INSERT, KEY_ONES, '0, ADDR_MIN, 1'b1, ste_pkg::ST_OK});
    rows.push_back('{ste_pkg::CMD_INSERT, KEY_ZERO, '1, ADDR_MAX, 1'b1, ste_pkg::ST_OK});
    rows.push_back('{ste_pkg::CMD_INSERT, KEY_MAIN, TYPE_INT, -32'sd1, 1'b1, ste_pkg::ST_OK});
    rows.push_back('{ste_pkg::CMD_INSERT, KEY_MAIN, TYPE_FLT, 32'sd0, 1'b1, ste_pkg::ST_OK});
    rows.push_back('{ste_pkg::CMD_SEARCH, KEY_ONES, '0, '0, 1'b0, ste_pkg::ST_OK});
    rows.push_back('{ste_pkg::CMD_SEARCH, KEY_ZERO, '0, '0, 1'b0, ste_pkg::ST_OK});
    rows.push_back('{ste_pkg::CMD_SEARCH, KEY_MAIN, '1, '0, 1'b0, ste_pkg::ST_OK});
    rows.push_back('{ste_pkg::CMD_SEARCH, KEY_COUNT, '0, '0, 1'b1, ste_pkg::ST_NOT_FOUND});
    rows.push_back('{ste_pkg::CMD_DISPLAY, KEY_ONES, '1, ADDR_MIN, 1'b0, ste_pkg::ST_OK});
    rows.push_back('{ste_pkg::CMD_DELETE, KEY_MAIN, '0, '0, 1'b0, ste_pkg::ST_OK});
    rows.push_back('{ste_pkg::CMD_SEARCH, KEY_MAIN, '0, '0, 1'b0, ste_pkg::ST_OK});
    rows.push_back('{ste_pkg::CMD_DELETE, KEY_COUNT, '0, '0, 1'b1, ste_pkg::ST_NOT_FOUND});
    rows.push_back('{ste_pkg::CMD_DELETE, KEY_ONES, '0, '0, 1'b0, ste_pkg::ST_OK});
    rows.push_back('{ste_pkg::CMD_DISPLAY, KEY_ZERO, '0, '0, 1'b0, ste_pkg::ST_OK});
    rows.push_back('{ste_pkg::CMD_DELETE, KEY_ZERO, '0, '0, 1'b0, ste_pkg::ST_OK});
    rows.push_back('{ste_pkg::CMD_DELETE, KEY_MAIN, '0, '0, 1'b0, ste_pkg::ST_OK});
    rows.push_back('{ste_pkg::CMD_DISPLAY, KEY_ZERO, '0, '0, 1'b1, ste_pkg::ST_EMPTY});
    rows.push_back('{ste_pkg::CMD_SEARCH, KEY_MAIN, '0, '0, 1'b1, ste_pkg::ST_NOT_FOUND});
    rows.push_back('{ste_pkg::CMD_INSERT, KEY_X, TYPE_CHR, 32'sh1234_5678, 1'b1, ste_pkg::ST_OK});
    rows.push_back('{ste_pkg::CMD_DISPLAY, KEY_ZERO, '0, '0, 1'b0, ste_pkg::ST_OK});
    rows.push_back('{ste_pkg::CMD_DELETE, KEY_X, '0, '0, 1'b0, ste_pkg::ST_OK});

    foreach (rows[k]) begin
      row = rows[k];
      send_request(row.cmd, row.key, row.typ, row.addr);
      // Rows with a typed result replace the predicted one.
      if (row.fixed) begin
        void'(awaited.pop_back());
        queue_reply(row.fixed_status, '0, '0, '0, 1'b1);
      end
    end
    wait_for_results();

    // Mixed traffic; the result side holds off once while requests keep coming.
    for (n = 0; n < 150; n++) begin
      if (n == 60) hold_outputs = 1'b1;
      if (n == 100) wait_for_results();
      send_random(4, 3, 3, 1);
    end

    // Fill the table, push past capacity, then work close to full.
    while (tbl_count < DEPTH) send_random(8, 1, 0, 0);
    for (n = 0; n < 3; n++) send_random(1, 0, 0, 0);
    send_request(ste_pkg::CMD_DISPLAY, pick_key(), {$urandom, $urandom}, $urandom);
    for (n = 0; n < 30; n++) send_random(3, 2, 3, 0);
    wait_for_results();

    // Drain the table back to empty.
    for (n = 0; n < 100 && tbl_count > 0; n++) send_random(1, 2, 6, 1);
    while (tbl_count > 0) send_random(0, 0, 1, 0);
    send_request(ste_pkg::CMD_DISPLAY, pick_key(), {$urandom, $urandom}, $urandom);

    // Unbiased noise to finish.
    for (n = 0; n < 40; n++) send_random(1, 1, 1, 1);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d requests (insert %0d, search %0d, delete %0d, display %0d), %0d results.",
             requests_sent, op_count[ste_pkg::CMD_INSERT], op_count[ste_pkg::CMD_SEARCH],
             op_count[ste_pkg::CMD_DELETE], op_count[ste_pkg::CMD_DISPLAY], results_seen);
    $display("Inserts on a full table: %0d, longest listing: %0d, output hold-offs: %0d.",
             full_inserts, longest_listing, holds_done);
    if (error_count == 0) begin
      $display("symbol_table_engine test passed");
    end else begin
      $display("%0d errors", error_count);
      $display("symbol_table_engine test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ste_pkg.sv
rtl/symbol_table_engine.sv
test/tb_symbol_table_engine.sv
